>>> hw/rtl/hce_pkg.sv
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types, constants and helpers for the Hill cipher encryptor.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int MAX_BLOCK   = 4;
  localparam int PEND_DEPTH  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CHAR_W    = 8;
  localparam int LET_W     = 5;
  localparam int COEF_W    = 5;
  localparam int KEY_W     = MAX_BLOCK * COEF_W;
  localparam int BSIZE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = KEY_W;
  localparam int PCNT_W    = $clog2(PEND_DEPTH + 1);
  localparam int PIDX_W    = $clog2(PEND_DEPTH);
  localparam int LCNT_W    = $clog2(MAX_BLOCK + 1);
  localparam int BIDX_W    = $clog2(MAX_BLOCK);
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W    = LET_W + COEF_W;
  localparam int MSUM_W    = PROD_W;

  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
  localparam logic [LET_W-1:0]  PAD_LETTER = 5'd23;  // 'X' - 'A'
  localparam int                MODULUS    = 26;
  // floor(t / 26) == (t * RECIP_26) >> RECIP_SH for every t below 1024
  localparam int                RECIP_26   = 2521;
  localparam int                RECIP_SH   = 16;
  localparam int                QPROD_W    = MSUM_W + 12;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_3  = 3'd4;

  typedef logic [MAX_BLOCK-1:0][KEY_W-1:0] key_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_letter;
    logic              eom;
  } hce_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_ONE
  } back_state_t;

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

  function automatic logic [LET_W-1:0] mod26(input logic [MSUM_W-1:0] t);
    logic [QPROD_W-1:0] qp;
    logic [MSUM_W-1:0]  q;
    logic [MSUM_W-1:0]  r;
    qp = QPROD_W'(t) * QPROD_W'(RECIP_26);
    q  = MSUM_W'(qp >> RECIP_SH);
    r  = t - MSUM_W'(q * MSUM_W'(MODULUS));
    return r[LET_W-1:0];
  endfunction

endpackage

>>> hw/rtl/hce_front.sv
// ----------------------------------------------------------------------------
// hce_front
// Input side: take beats, classify each character, hold them in a short queue.
// ----------------------------------------------------------------------------
module hce_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [hce_pkg::CHAR_W-1:0] in_char,
  input  logic                  in_eom,
  output logic                  cmd_valid,
  output hce_pkg::hce_cmd_t     cmd,
  input  logic                  cmd_pop
);
  import hce_pkg::*;

  hce_cmd_t          q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign in_ready  = (count < QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{ch: in_char, is_letter: is_upper(in_char), eom: in_eom};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (cmd_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end
  end

endmodule

>>> hw/rtl/hce_back.sv
// ----------------------------------------------------------------------------
// hce_back
// Execution side: block state, pending buffer, key multiply and result emit.
// ----------------------------------------------------------------------------
module hce_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  hce_pkg::hce_cmd_t           cmd,
  output logic                        cmd_pop,
  input  logic [hce_pkg::BSIZE_W-1:0] block_size,
  input  hce_pkg::key_t               key_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hce_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_last,
  output logic                        out_done,
  output logic                        out_drop
);
  import hce_pkg::*;

  back_state_t       state;
  back_state_t       state_next;

  logic [CHAR_W-1:0] pend [PEND_DEPTH];
  logic [PCNT_W-1:0] pc;
  logic [LET_W-1:0]  letters [MAX_BLOCK];
  logic [LCNT_W-1:0] lc;
  logic              eom_r;
  logic              drop_r;
  logic [CHAR_W-1:0] one_char;
  logic [LCNT_W-1:0] dim;
  logic [BIDX_W-1:0] row;
  logic [PROD_W-1:0] prod [MAX_BLOCK];
  logic [LET_W-1:0]  acc [MAX_BLOCK];
  logic [PCNT_W-1:0] ptr;
  logic [LCNT_W-1:0] kc;

  // pop decision
  logic [LCNT_W-1:0] bs;
  logic [LCNT_W-1:0] lc_new;
  logic [LCNT_W-1:0] dim_new;
  logic [LCNT_W-1:0] need;
  logic              store;
  logic              dropped;
  logic              flush;
  logic              single;
  logic [CHAR_W-1:0] single_char;

  // emit
  logic              can_emit;
  logic              fire;
  logic              in_pend;
  logic [CHAR_W-1:0] pch;
  logic              use_cipher;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              emit_done;
  logic              emit_drop;
  logic [LCNT_W-1:0] kc_next;
  logic [PCNT_W-1:0] ptr_next;
  logic              last_row;
  logic [LET_W-1:0]  row_letter;

  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign can_emit = !out_valid || out_ready;
  assign last_row = ({1'b0, row} == (dim - 1'b1));
  assign row_letter = ({1'b0, row} < lc) ? letters[row] : PAD_LETTER;

  always_comb begin
    if (block_size == '0) bs = LCNT_W'(1);
    else if (LCNT_W'(block_size) > LCNT_W'(MAX_BLOCK)) bs = LCNT_W'(MAX_BLOCK);
    else bs = LCNT_W'(block_size);
  end

  always_comb begin
    store       = 1'b0;
    dropped     = 1'b0;
    flush       = 1'b0;
    single      = 1'b0;
    single_char = CHAR_NONE;
    lc_new      = lc;
    need        = LCNT_W'(1);
    if (cmd.is_letter) begin
      store   = (pc < PCNT_W'(PEND_DEPTH)) && (lc < LCNT_W'(MAX_BLOCK));
      dropped = !store;
      lc_new  = lc + LCNT_W'(store);
      flush   = (lc_new != '0) && ((lc_new >= bs) || cmd.eom);
    end else if (lc == '0) begin
      single      = 1'b1;
      single_char = cmd.ch;
    end else begin
      // keep room for the letters still missing from the block
      if (!cmd.eom && (bs > lc)) need = LCNT_W'(1) + (bs - lc);
      store   = ((PCNT_W + 1)'(pc) + (PCNT_W + 1)'(need)) <= (PCNT_W + 1)'(PEND_DEPTH);
      dropped = !store;
      flush   = cmd.eom;
    end
    if (!flush && dropped) single = 1'b1;
    dim_new = (lc_new > bs) ? lc_new : bs;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (flush) state_next = ST_MUL;
          else if (single) state_next = ST_ONE;
        end
      end
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = last_row ? ST_EMIT : ST_MUL;
      ST_EMIT: if (fire && emit_last) state_next = ST_IDLE;
      ST_ONE:  if (fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_pend    = ptr < pc;
    pch        = pend[ptr[PIDX_W-1:0]];
    use_cipher = !in_pend || (is_upper(pch) && (kc < dim));
    kc_next    = kc + LCNT_W'(use_cipher);
    ptr_next   = ptr + PCNT_W'(in_pend);
    fire       = 1'b0;
    emit_char  = one_char;
    emit_last  = 1'b1;
    emit_done  = eom_r;
    emit_drop  = drop_r;
    case (state)
      ST_EMIT: begin
        fire      = can_emit;
        emit_char = use_cipher ? (CHAR_A + CHAR_W'(acc[kc[BIDX_W-1:0]])) : pch;
        emit_last = (ptr_next >= pc) && (kc_next >= dim);
        emit_done = eom_r && emit_last;
      end
      ST_ONE: begin
        fire = can_emit;
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (store) pend[pc[PIDX_W-1:0]] <= cmd.ch;
      if (store && cmd.is_letter) letters[lc[BIDX_W-1:0]] <= LET_W'(cmd.ch - CHAR_A);
      eom_r    <= cmd.eom;
      drop_r   <= dropped;
      one_char <= single_char;
      dim      <= dim_new;
      row      <= '0;
      ptr      <= '0;
      kc       <= '0;
      for (int i = 0; i < MAX_BLOCK; i++) acc[i] <= '0;
    end
    if (state == ST_MUL) begin
      for (int i = 0; i < MAX_BLOCK; i++) begin
        prod[i] <= PROD_W'(row_letter) * PROD_W'(key_row[row][i*COEF_W +: COEF_W]);
      end
    end
    if (state == ST_ACC) begin
      for (int i = 0; i < MAX_BLOCK; i++) begin
        acc[i] <= mod26(MSUM_W'(acc[i]) + MSUM_W'(prod[i]));
      end
      row <= row + 1'b1;
    end
    if (fire && (state == ST_EMIT)) begin
      ptr <= ptr_next;
      kc  <= kc_next;
    end
    if (fire) begin
      out_char <= emit_char;
      out_last <= emit_last;
      out_done <= emit_done;
      out_drop <= emit_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      lc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        pc <= pc + PCNT_W'(store);
        lc <= lc_new;
      end
      if (fire && (state == ST_EMIT) && emit_last) begin
        pc <= '0;
        lc <= '0;
      end
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/hill_cipher_encryptor_top.sv
// ----------------------------------------------------------------------------
// hill_cipher_encryptor_top
// Hill cipher encryptor for a byte stream, key matrix and block size by register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per beat in tdata; tlast marks the end of the
//   message, which pads an open block with 'X' and flushes it.
//   m_axis carries result characters; tlast marks the last result caused by
//   one input beat, tuser[0] the last result of an end-of-message beat and tuser[1]
//   every result of a beat whose character was dropped on a full buffer.
//   cfg writes block_size (index 0) and key rows 0..3 (index 1..4); it is always
//   ready; the user must write it only while the block is idle, which it does not enforce.
// Timing:
//   A two-beat queue takes input beats while the back end works. The back end
//   takes a beat in its idle state; a beat that only fills the buffer is done
//   there, a pass-through or a drop adds an emit state. A flushing beat of
//   dimension d runs the key multiply as one multiply/reduce pair per key row,
//   all columns in parallel, then emits one result per cycle while m_axis is
//   not stalled; every result leaves through an output register.
// Reset (synchronous, rst high) empties the queue and the block, sets
//   block_size to 3 and the key to zero; no clearing pass is needed.
// A stalled m_axis holds the result register; the queue fills and then
//   s_axis_tready drops until the back end moves again.
// ----------------------------------------------------------------------------
module hill_cipher_encryptor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_in
  input  logic                          s_axis_tlast,   // end_of_message
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] char_out
  output logic                          m_axis_tlast,   // last_of_run
  output logic [1:0]                    m_axis_tuser,   // [0] message_done, [1] dropped_flag
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hce_pkg::CFG_DAT_W-1:0] cfg_data
);
  import hce_pkg::*;

  logic [BSIZE_W-1:0] block_size;
  key_t               key_row;
  logic               cfg_we;

  hce_cmd_t           cmd;
  logic               cmd_valid;
  logic               cmd_pop;

  logic               res_done;
  logic               res_drop;

  // Register writes land in the next cycle; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BSIZE_W'(3);
      key_row    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: block_size <= cfg_data[BSIZE_W-1:0];
        CFG_KEY_ROW_0:  key_row[0] <= cfg_data[KEY_W-1:0];
        CFG_KEY_ROW_1:  key_row[1] <= cfg_data[KEY_W-1:0];
        CFG_KEY_ROW_2:  key_row[2] <= cfg_data[KEY_W-1:0];
        CFG_KEY_ROW_3:  key_row[3] <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify beats and queue them.
  hce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .in_eom    (s_axis_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: buffer, multiply, emit.
  hce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .block_size (block_size),
    .key_row    (key_row),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_done   (res_done),
    .out_drop   (res_drop)
  );

  assign m_axis_tuser = {res_drop, res_done};

endmodule

>>> tb/sv/hce_cipher_checker.sv
// ----------------------------------------------------------------------------
// hce_cipher_checker
// Watches the character, result and register channels of the Hill cipher
// encryptor, predicts every result beat and compares it with the DUT output.
// ----------------------------------------------------------------------------
module hce_cipher_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_in
  input  logic                          s_axis_tlast,   // end_of_message
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [7:0]                    m_axis_tdata,   // [7:0] char_out
  input  logic                          m_axis_tlast,   // last_of_run
  input  logic [1:0]                    m_axis_tuser,   // [0] message_done, [1] dropped_flag
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [hce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hce_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            errors,
  output int                            results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import hce_pkg::*;

  localparam int MAX_RUN = PEND_DEPTH + MAX_BLOCK;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              run_end;
    logic              msg_done;
    logic              dropped;
  } cipher_beat_t;

  cipher_beat_t      cipher_q [$];
  logic [CHAR_W-1:0] run_chars [MAX_RUN];
  int                run_n;

  logic [BSIZE_W-1:0] size_r;
  logic [KEY_W-1:0]   key_r [MAX_BLOCK];
  logic [CHAR_W-1:0]  held_chars [PEND_DEPTH];
  int                 held_cnt;
  logic [LET_W-1:0]   block_let [MAX_BLOCK];
  int                 letter_cnt;

  // Clamp the block size register to 1..MAX_BLOCK.
  function automatic int key_dim();
    int n;
    n = int'(size_r);
    if (n < 1) n = 1;
    if (n > MAX_BLOCK) n = MAX_BLOCK;
    return n;
  endfunction

  // Append one character to the results of the current beat.
  task automatic add_char(input logic [CHAR_W-1:0] ch);
    run_chars[run_n] = ch;
    run_n++;
  endtask

  // Pad, multiply by key; emit held chars with letters replaced, then leftover cipher letters.
  task automatic flush_block();
    int                dim;
    int                k;
    int                sum;
    logic [CHAR_W-1:0] cipher [MAX_BLOCK];
    dim = key_dim();
    if (letter_cnt > dim) dim = letter_cnt;
    for (int i = letter_cnt; i < dim; i++) block_let[i] = PAD_LETTER;
    for (int i = 0; i < dim; i++) begin
      sum = 0;
      for (int j = 0; j < dim; j++)
        sum += int'(block_let[j]) * int'(key_r[j][COEF_W*i +: COEF_W]);
      cipher[i] = CHAR_A + CHAR_W'(sum % MODULUS);
    end
    k = 0;
    for (int i = 0; i < held_cnt; i++) begin
      if (held_chars[i] >= CHAR_A && held_chars[i] <= CHAR_Z && k < dim) begin
        add_char(cipher[k]);
        k++;
      end else begin
        add_char(held_chars[i]);
      end
    end
    while (k < dim) begin
      add_char(cipher[k]);
      k++;
    end
    held_cnt   = 0;
    letter_cnt = 0;
  endtask

  task automatic encipher_char(input logic [CHAR_W-1:0] ch, input logic eom);
    int           dim;
    int           need;
    logic         dropped;
    cipher_beat_t beat;
    run_n   = 0;
    dropped = 1'b0;
    dim     = key_dim();
    if (ch >= CHAR_A && ch <= CHAR_Z) begin
      if (held_cnt < PEND_DEPTH && letter_cnt < MAX_BLOCK) begin
        held_chars[held_cnt] = ch;
        held_cnt++;
        block_let[letter_cnt] = LET_W'(ch - CHAR_A);
        letter_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (letter_cnt > 0 && (letter_cnt >= dim || eom)) flush_block();
    end else if (letter_cnt == 0) begin
      add_char(ch);
    end else begin
      // keep room for the letters the open block still lacks
      need = eom ? 1 : 1 + ((dim > letter_cnt) ? dim - letter_cnt : 0);
      if (held_cnt + need <= PEND_DEPTH) begin
        held_chars[held_cnt] = ch;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (eom) flush_block();
    end
    if (run_n == 0 && dropped) add_char(CHAR_NONE);
    for (int i = 0; i < run_n; i++) begin
      beat.ch       = run_chars[i];
      beat.run_end  = (i == run_n - 1);
      beat.msg_done = beat.run_end && eom;
      beat.dropped  = dropped;
      cipher_q.insert(cipher_q.size(), beat);
    end
  endtask

  always @(posedge clk) begin
    cipher_beat_t want;
    cipher_beat_t got;
    if (rst) begin
      size_r       = 3'd3;
      key_r        = '{default: '0};
      held_cnt     = 0;
      letter_cnt   = 0;
      run_n        = 0;
      cipher_q.delete();
      errors       <= 0;
      results_owed <= 0;
    end else begin
      // compare before predicting so a stray beat never matches a fresh entry
      if (m_axis_tvalid && m_axis_tready) begin
        got.ch       = m_axis_tdata;
        got.run_end  = m_axis_tlast;
        got.msg_done = m_axis_tuser[0];
        got.dropped  = m_axis_tuser[1];
        if (cipher_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 40)
            $display("%0t hce_cipher_checker: unexpected beat, expected none, %s",
                     $time, "got:");
          if (errors < 40)
            $display("  ch=%h last=%b done=%b drop=%b",
                     got.ch, got.run_end, got.msg_done, got.dropped);
        end else begin
          want = cipher_q.pop_front();
          if (got != want) begin
            errors <= errors + 1;
            if (errors < 40)
              $display("%0t hce_cipher_checker: expected ch=%h last=%b done=%b drop=%b,",
                       $time, want.ch, want.run_end, want.msg_done, want.dropped);
            if (errors < 40)
              $display("  got ch=%h last=%b done=%b drop=%b",
                       got.ch, got.run_end, got.msg_done, got.dropped);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) encipher_char(s_axis_tdata, s_axis_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK_SIZE: size_r = cfg_data[BSIZE_W-1:0];
          CFG_KEY_ROW_0:  key_r[0] = cfg_data[KEY_W-1:0];
          CFG_KEY_ROW_1:  key_r[1] = cfg_data[KEY_W-1:0];
          CFG_KEY_ROW_2:  key_r[2] = cfg_data[KEY_W-1:0];
          CFG_KEY_ROW_3:  key_r[3] = cfg_data[KEY_W-1:0];
          default: ;
        endcase
      end
      results_owed <= cipher_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives character streams and register writes into the Hill cipher
// encryptor with random gaps and output stalls; a checker beside the DUT
// predicts every result beat, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hce_pkg::*;

  // random beats on top of the directed ones
  localparam int RANDOM_ITEMS   = 150;
  // drain pause, long enough for a block of four plus a full buffer
  localparam int DRAIN_CYCLES   = 64;
  // longest legal quiet stretch is the drain pause plus a stalled flush
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = 8'h00;   // [7:0] char_in
  logic                 s_axis_tlast  = 1'b0;    // end_of_message
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;            // [7:0] char_out
  logic                 m_axis_tlast;            // last_of_run
  logic [1:0]           m_axis_tuser;            // [0] message_done, [1] dropped_flag
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_BLOCK_SIZE;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;

  int   errors;
  int   results_owed;
  int   quiet_cycles = 0;
  int   sink_stall   = 0;
  int   sink_gap;
  int   items_sent;
  // set for whole phases: no gaps on either side
  logic steady       = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hill_cipher_encryptor_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  hce_cipher_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .results_owed  (results_owed)
  );

  // Result sink: after each accepted beat, draw a random stall, possibly none,
  // and hold tready low for that long; steady phases never stall.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= 0;
    end else if (!m_axis_tready) begin
      if (sink_stall == 0) m_axis_tready <= 1'b1;
      else sink_stall <= sink_stall - 1;
    end else if (m_axis_tvalid) begin
      sink_gap = steady ? 0 : $urandom_range(0, 15);
      if (sink_gap != 0) begin
        m_axis_tready <= 1'b0;
        sink_stall    <= sink_gap - 1;
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  // Send one character beat. Leave tvalid high on return so a back-to-back
  // beat only updates data; lower it only when a gap is drawn.
  task automatic send_char(input logic [7:0] ch, input logic eom);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop tvalid, wait for every predicted beat, then let a block that is
  // still busy on beats with no result finish before touching registers.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write block_size and all four key rows, one beat per register.
  task automatic load_config(input logic [BSIZE_W-1:0] bsize,
                             input logic [KEY_W-1:0] r0, input logic [KEY_W-1:0] r1,
                             input logic [KEY_W-1:0] r2, input logic [KEY_W-1:0] r3);
    logic [CFG_DAT_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0] idx  [5];
    vals = '{CFG_DAT_W'(bsize), r0, r1, r2, r3};
    idx  = '{CFG_BLOCK_SIZE, CFG_KEY_ROW_0, CFG_KEY_ROW_1, CFG_KEY_ROW_2, CFG_KEY_ROW_3};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Key row: all zero, all 31, or random coefficients.
  function automatic logic [KEY_W-1:0] pick_key_row(input int mode);
    if (mode == 0) return '0;
    if (mode == 1) return '1;
    return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
  endfunction

  // Uppercase letter with the given percentage, otherwise any other byte.
  function automatic logic [7:0] pick_char(input int letter_pct);
    logic [7:0] c;
    if ($urandom_range(0, 99) < letter_pct)
      return CHAR_A + 8'($urandom_range(0, MODULUS - 1));
    do c = 8'($urandom_range(0, 255));
    while (c >= CHAR_A && c <= CHAR_Z);
    return c;
  endfunction

  initial begin
    logic [BSIZE_W-1:0] bsize;
    int                 key_mode;
    int                 letter_pct;
    int                 eom_odds;
    int                 phase_len;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 3x3 key, byte extremes, the ends of the letter range and a
    // neighbor above it, a full block, then a padded partial block at end of message.
    load_config(3'd3, {5'd0, 5'd1, 5'd24, 5'd6}, {5'd0, 5'd10, 5'd16, 5'd13},
                {5'd0, 5'd15, 5'd17, 5'd20}, '0);
    send_char(8'h00, 1'b0);
    send_char("A", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("Z", 1'b0);
    send_char("[", 1'b0);
    send_char("M", 1'b0);
    send_char("Q", 1'b1);
    drain();

    // Directed: largest coefficients, block of two; fill the buffer until a
    // non-letter drops with nothing to emit, then raise the block size with
    // the block open so a letter finds the buffer full, and flush on a
    // non-letter that is dropped too.
    load_config(3'd2, '1, '1, '1, '1);
    send_char("C", 1'b0);
    repeat (15) send_char("#", 1'b0);
    drain();
    load_config(3'd4, '1, '1, '1, '1);
    send_char("D", 1'b0);
    send_char("E", 1'b0);
    send_char("?", 1'b1);
    drain();

    // Random phases: new registers each time (out-of-range block sizes now
    // and then, often with a block left open so the size changes mid-block),
    // mostly text with letters, some noise phases that fill the buffer.
    while (items_sent < RANDOM_ITEMS) begin
      bsize    = ($urandom_range(0, 3) == 0) ? BSIZE_W'($urandom_range(0, 7))
                                             : BSIZE_W'($urandom_range(1, MAX_BLOCK));
      key_mode = $urandom_range(0, 7);
      load_config(bsize, pick_key_row(key_mode), pick_key_row(key_mode),
                  pick_key_row(key_mode), pick_key_row(key_mode));
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        letter_pct = 8;
        eom_odds   = 40;
      end else begin
        letter_pct = 70;
        eom_odds   = 10;
      end
      phase_len = $urandom_range(8, 24);
      repeat (phase_len) begin
        send_char(pick_char(letter_pct), $urandom_range(1, eom_odds) == 1);
        items_sent++;
      end
      drain();
    end

    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hce_pkg.sv
hw/rtl/hce_front.sv
hw/rtl/hce_back.sv
hw/rtl/hill_cipher_encryptor_top.sv
tb/sv/hce_cipher_checker.sv
tb/sv/tb_top.sv
